FILE: rtl/core/ssfm_pkg.sv
// ----------------------------------------------------------------------------
// ssfm_pkg
// Shared types and constants for the first-match substring search block.
// ----------------------------------------------------------------------------
package ssfm_pkg;

	localparam int BYTE_W = 8;
	localparam int IDX_W  = 8;

	// Input word opcodes
	typedef enum logic [1:0] {
		MODE_PATTERN = 2'd0,
		MODE_TEXT    = 2'd1,
		MODE_EMPTY   = 2'd2,
		MODE_END     = 2'd3
	} mode_t;

	// Broadcast controls from the sequencer to every cell
	typedef struct packed {
		logic load;        // shift pattern chain by one byte
		logic clear_pat;   // drop the whole pattern
		logic text;        // advance partial-match flags on a text byte
		logic clear_text;  // zero all partial-match flags
	} cell_ctrl_t;

endpackage

FILE: rtl/core/ssfm_in_if.sv
// ----------------------------------------------------------------------------
// ssfm_in_if
// Input channel: one pattern/text/command word per handshake.
// ----------------------------------------------------------------------------
interface ssfm_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [7:0]  data_byte;
	logic        last;

	modport source (output valid, output mode, output data_byte, output last, input ready);
	modport sink   (input valid, input mode, input data_byte, input last, output ready);
endinterface

FILE: rtl/core/ssfm_out_if.sv
// ----------------------------------------------------------------------------
// ssfm_out_if
// Result channel: one search result word per text.
// ----------------------------------------------------------------------------
interface ssfm_out_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [7:0]  match_index;

	modport source (output valid, output found, output match_index, input ready);
	modport sink   (input valid, input found, input match_index, output ready);
endinterface

FILE: rtl/core/ssfm_cell.sv
// ----------------------------------------------------------------------------
// ssfm_cell
// One pattern position: holds a pattern byte, its valid bit and the
// partial-match flag for that position.
// ----------------------------------------------------------------------------
module ssfm_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ssfm_pkg::cell_ctrl_t                ctrl,
	input  logic [ssfm_pkg::BYTE_W-1:0]         data_byte,
	input  logic [ssfm_pkg::BYTE_W-1:0]         prev_byte,
	input  logic                                prev_vld,
	input  logic                                carry_in,
	output logic [ssfm_pkg::BYTE_W-1:0]         byte_q,
	output logic                                vld_q,
	output logic                                carry_out,
	output logic                                hit
);

	logic flag_q;

	// Cells are loaded newest-first: the last pattern byte sits in cell 0 and
	// the prefix flag travels toward cell 0 one position per text byte.
	assign hit       = vld_q & carry_in & (byte_q == data_byte);
	// An unused cell above the pattern supplies an always-true prefix
	assign carry_out = vld_q ? flag_q : 1'b1;

	// Pattern byte shift stage
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			byte_q <= prev_byte;
		end
	end

	// Valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctrl.clear_pat) begin
			vld_q <= 1'b0;
		end else if (ctrl.load) begin
			vld_q <= prev_vld;
		end
	end

	// Partial-match flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (ctrl.clear_text) begin
			flag_q <= 1'b0;
		end else if (ctrl.text) begin
			flag_q <= hit;
		end
	end

endmodule

FILE: rtl/core/substring_search_first_match.sv
// ----------------------------------------------------------------------------
// substring_search_first_match
// Streaming exact substring search reporting the first match position.
//
// Load a pattern with mode 0 words (last closes it; a pattern word after a
// closed pattern starts a new one), or set an empty pattern with mode 2.
// Stream text with mode 1 words; a text word with last set, or an end word
// (mode 3), produces one result word: found and the 1-based start of the
// earliest occurrence, or 0. The result word is valid from the cycle after
// the accepting edge. Input words are accepted back to back; each text
// word updates all pattern positions at once in a row of MAX_LEN cells,
// one per pattern byte, and the only stall comes from a result word
// still waiting downstream. There is no clearing pass after reset.
// Pattern and text bytes past MAX_LEN are dropped.
// ----------------------------------------------------------------------------
module substring_search_first_match #(
	parameter int MAX_LEN = 255
) (
	input  logic            clk,
	input  logic            arst_n,
	ssfm_in_if.sink         in_ch,
	ssfm_out_if.source      out_ch
);

	localparam logic [ssfm_pkg::IDX_W-1:0] MaxL = ssfm_pkg::IDX_W'(MAX_LEN);

	ssfm_pkg::mode_t        mode;
	ssfm_pkg::cell_ctrl_t   ctrl;
	logic                   acc;
	logic                   restart;
	logic                   take;
	logic                   emit;
	logic                   closed_q;
	logic [ssfm_pkg::IDX_W-1:0] len_q;
	logic [ssfm_pkg::IDX_W-1:0] pos_q;
	logic [ssfm_pkg::IDX_W-1:0] first_q;
	logic [ssfm_pkg::IDX_W-1:0] first_nxt;
	logic [ssfm_pkg::IDX_W:0]   start_sum;
	logic                   out_vld_q;
	logic                   found_q;
	logic [ssfm_pkg::IDX_W-1:0] idx_q;

	logic [ssfm_pkg::BYTE_W-1:0] cell_byte [MAX_LEN];
	logic [MAX_LEN-1:0]          cell_vld;
	logic [MAX_LEN-1:0]          cell_carry;
	logic [MAX_LEN-1:0]          cell_hit;

	// Handshake and word decode
	assign in_ch.ready = ~out_vld_q | out_ch.ready;
	assign acc         = in_ch.valid & in_ch.ready;
	assign mode        = ssfm_pkg::mode_t'(in_ch.mode);

	assign restart = acc & (mode == ssfm_pkg::MODE_PATTERN) & closed_q;
	assign take    = acc & (mode == ssfm_pkg::MODE_TEXT) & (pos_q < MaxL);
	assign emit    = acc & ((mode == ssfm_pkg::MODE_END) |
		((mode == ssfm_pkg::MODE_TEXT) & in_ch.last));

	assign ctrl.load       = acc & (mode == ssfm_pkg::MODE_PATTERN) &
		(closed_q | (len_q < MaxL));
	assign ctrl.clear_pat  = acc & (mode == ssfm_pkg::MODE_EMPTY);
	assign ctrl.text       = take;
	assign ctrl.clear_text = restart | ctrl.clear_pat | emit;

	// Cell row
	for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
		logic [ssfm_pkg::BYTE_W-1:0] prev_byte;
		logic                        prev_vld;
		logic                        carry_in;

		if (k == 0) begin : g_head
			assign prev_byte = in_ch.data_byte;
			assign prev_vld  = 1'b1;
		end else begin : g_body
			assign prev_byte = cell_byte[k-1];
			assign prev_vld  = cell_vld[k-1] & ~restart;
		end

		if (k == MAX_LEN - 1) begin : g_top
			assign carry_in = 1'b1;
		end else begin : g_mid
			assign carry_in = cell_carry[k+1];
		end

		ssfm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.data_byte (in_ch.data_byte),
			.prev_byte (prev_byte),
			.prev_vld  (prev_vld),
			.carry_in  (carry_in),
			.byte_q    (cell_byte[k]),
			.vld_q     (cell_vld[k]),
			.carry_out (cell_carry[k]),
			.hit       (cell_hit[k])
		);
	end

	// Earliest match start: position + 2 - length on a full match
	assign start_sum = {1'b0, pos_q} + (ssfm_pkg::IDX_W+1)'(2) - {1'b0, len_q};
	assign first_nxt = (take && cell_hit[0] && (first_q == '0)) ?
		start_sum[ssfm_pkg::IDX_W-1:0] : first_q;

	// Pattern length and open/closed state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			closed_q <= 1'b1;
		end else if (acc) begin
			case (mode)
				ssfm_pkg::MODE_PATTERN: begin
					if (closed_q) begin
						len_q <= ssfm_pkg::IDX_W'(1);
					end else if (len_q < MaxL) begin
						len_q <= len_q + 1'b1;
					end
					closed_q <= in_ch.last;
				end
				ssfm_pkg::MODE_TEXT: begin
					closed_q <= 1'b1;
				end
				ssfm_pkg::MODE_EMPTY: begin
					len_q    <= '0;
					closed_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Text position and first match
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			first_q <= '0;
		end else if (ctrl.clear_text) begin
			pos_q   <= '0;
			first_q <= '0;
		end else if (take) begin
			pos_q   <= pos_q + 1'b1;
			first_q <= first_nxt;
		end
	end

	// Result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit) begin
			out_vld_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			found_q <= (first_nxt != '0);
			idx_q   <= first_nxt;
		end
	end

	assign out_ch.valid       = out_vld_q;
	assign out_ch.found       = found_q;
	assign out_ch.match_index = idx_q;

endmodule

FILE: tb/substring_search_first_match_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// substring_search_first_match_tb
// Self-checking bench for the first-match substring search block. Words go
// in through a randomly idling sender. An in-bench shift-and search predicts
// each result word. A randomly stalling receiver compares every result field
// against the oldest prediction. It covers directed corner cases, pattern and
// text overflow, output backpressure, sender pauses and a long run of random searches.
// ----------------------------------------------------------------------------
module substring_search_first_match_tb;

	localparam int MAX_LEN        = 255;
	localparam int RESET_CYCLES   = 9;
	localparam int SETTLE_CYCLES  = 20;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_WORDS   = 110;

	typedef struct packed {
		logic       found;
		logic [7:0] match_index;
	} search_result_t;

	logic clk = 1'b0;
	logic arst_n;

	ssfm_in_if  in_ch ();
	ssfm_out_if out_ch ();

	substring_search_first_match #(
		.MAX_LEN(MAX_LEN)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predicted search state
	logic [7:0]     pat_bytes [MAX_LEN];
	bit             prefix_hit [MAX_LEN];
	int             pat_len;
	bit             pat_closed;
	int             text_pos;
	int             first_start;
	search_result_t expected_results [$];

	// Run bookkeeping
	int words_sent;
	int results_checked;
	int errors;
	int idle_cycles;
	int in_gap_max;
	int out_stall_max;
	int rx_stall_left;
	int rx_hold_req;
	int rx_hold_left;

	// ------------------------------------------------------------------
	// Search predictor
	// ------------------------------------------------------------------
	function automatic void clear_search();
		for (int j = 0; j < MAX_LEN; j++)
			prefix_hit[j] = 1'b0;
		text_pos    = 0;
		first_start = 0;
	endfunction

	function automatic void close_text();
		search_result_t res;
		res.found       = (first_start != 0);
		res.match_index = 8'(first_start);
		expected_results.push_back(res);
		clear_search();
	endfunction

	// Shift-and update of all prefix flags on one text byte
	function automatic void scan_byte(input logic [7:0] b);
		if (text_pos >= MAX_LEN)
			return;
		if (pat_len > 0) begin
			for (int j = pat_len - 1; j > 0; j--)
				prefix_hit[j] = prefix_hit[j - 1] && (pat_bytes[j] == b);
			prefix_hit[0] = (pat_bytes[0] == b);
			if (prefix_hit[pat_len - 1] && first_start == 0)
				first_start = text_pos + 2 - pat_len;
		end
		text_pos++;
	endfunction

	function automatic void predict_word(input ssfm_pkg::mode_t m, input logic [7:0] b,
		input logic l);
		case (m)
			ssfm_pkg::MODE_PATTERN: begin
				// a pattern word after a closed pattern starts over
				if (pat_closed) begin
					pat_len    = 0;
					pat_closed = 1'b0;
					clear_search();
				end
				if (pat_len < MAX_LEN) begin
					pat_bytes[pat_len] = b;
					pat_len++;
				end
				if (l)
					pat_closed = 1'b1;
			end
			ssfm_pkg::MODE_TEXT: begin
				pat_closed = 1'b1;
				scan_byte(b);
				if (l)
					close_text();
			end
			ssfm_pkg::MODE_EMPTY: begin
				pat_len    = 0;
				pat_closed = 1'b1;
				clear_search();
			end
			ssfm_pkg::MODE_END: begin
				close_text();
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Result receiver: per-word stall, plus a long hold on request
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (rx_hold_req > 0) begin
			rx_hold_left = rx_hold_req;
			rx_hold_req  = 0;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			out_ch.ready <= 1'b0;
		end else if (rx_stall_left > 0) begin
			rx_stall_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	function automatic void check_result(input logic found, input logic [7:0] idx);
		search_result_t want;
		if (expected_results.size() == 0) begin
			errors++;
			$display("%0t ns: unexpected result word, expected none, actual found=%0b match_index=%0d",
				$time, found, idx);
			return;
		end
		want = expected_results.pop_front();
		results_checked++;
		if (want.found !== found) begin
			errors++;
			$display("%0t ns: found mismatch, expected %0b, actual %0b", $time, want.found, found);
		end
		if (want.match_index !== idx) begin
			errors++;
			$display("%0t ns: match_index mismatch, expected %0d, actual %0d",
				$time, want.match_index, idx);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			check_result(out_ch.found, out_ch.match_index);
			rx_stall_left = $urandom_range(0, out_stall_max);
		end
	end

	// Watchdog on handshake activity
	always @(posedge clk) begin
		if (arst_n !== 1'b1) begin
			idle_cycles = 0;
		end else if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
			(out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t ns: watchdog, no word moved for %0d cycles", $time, idle_cycles);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------
	// Returns right after the accepting edge with valid still high, so a
	// following word can go out back to back.
	task automatic send_word(input ssfm_pkg::mode_t m, input logic [7:0] b, input logic l);
		int gap;
		gap = $urandom_range(0, in_gap_max);
		repeat (gap) @(negedge clk) in_ch.valid <= 1'b0;
		@(negedge clk);
		in_ch.mode      <= m;
		in_ch.data_byte <= b;
		in_ch.last      <= l;
		in_ch.valid     <= 1'b1;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		predict_word(m, b, l);
		words_sent++;
	endtask

	task automatic send_pattern(input logic [7:0] bytes [$], input bit close);
		for (int i = 0; i < bytes.size(); i++)
			send_word(ssfm_pkg::MODE_PATTERN, bytes[i], close && (i == bytes.size() - 1));
	endtask

	task automatic send_text(input logic [7:0] bytes [$], input bit with_last);
		for (int i = 0; i < bytes.size(); i++)
			send_word(ssfm_pkg::MODE_TEXT, bytes[i], with_last && (i == bytes.size() - 1));
	endtask

	// Sender goes quiet until every predicted result has been taken
	task automatic drain_results();
		@(negedge clk) in_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_directed();
		in_gap_max    = 2;
		out_stall_max = 2;
		// end and text on the empty pattern left by reset
		send_word(ssfm_pkg::MODE_END, 8'hA5, 1'b1);
		send_word(ssfm_pkg::MODE_TEXT, 8'h00, 1'b1);
		// extreme bytes, match at the end of the text
		send_pattern({8'h00, 8'hFF}, 1'b1);
		send_text({8'hFF, 8'h00, 8'h00, 8'hFF}, 1'b1);
		// pattern longer than text
		send_pattern({8'h41, 8'h42, 8'h43}, 1'b1);
		send_text({8'h41, 8'h42}, 1'b1);
		// text closed by an end word instead of last
		send_text({8'h41, 8'h42, 8'h43}, 1'b0);
		send_word(ssfm_pkg::MODE_END, 8'hFF, 1'b0);
		// new pattern abandons the text; text word closes the open pattern
		send_text({8'h41, 8'h42}, 1'b0);
		send_word(ssfm_pkg::MODE_PATTERN, 8'h5A, 1'b0);
		send_word(ssfm_pkg::MODE_TEXT, 8'h5A, 1'b1);
		// empty-pattern command in mid-text
		send_word(ssfm_pkg::MODE_TEXT, 8'h5A, 1'b0);
		send_word(ssfm_pkg::MODE_EMPTY, 8'hFF, 1'b1);
		send_word(ssfm_pkg::MODE_TEXT, 8'h5A, 1'b1);
		// end word with no text taken
		send_word(ssfm_pkg::MODE_PATTERN, 8'h7F, 1'b1);
		send_word(ssfm_pkg::MODE_END, 8'h00, 1'b0);
	endtask

	task automatic test_overflow();
		in_gap_max    = 0;
		out_stall_max = 0;
		// pattern of MAX_LEN+1 bytes: the tail byte is dropped, its last still closes
		for (int i = 0; i < MAX_LEN + 1; i++)
			send_word(ssfm_pkg::MODE_PATTERN,
				(i < MAX_LEN - 1) ? 8'h61 : ((i == MAX_LEN - 1) ? 8'h62 : 8'h63),
				i == MAX_LEN);
		// full-length match ending on the last taken byte, one byte past the limit
		for (int i = 0; i < MAX_LEN + 1; i++)
			send_word(ssfm_pkg::MODE_TEXT, (i < MAX_LEN - 1) ? 8'h61 : 8'h62,
				i == MAX_LEN);
	endtask

	task automatic test_backpressure();
		in_gap_max    = 0;
		out_stall_max = 0;
		send_pattern({8'h31, 8'h32}, 1'b1);
		// a result word waits behind a stuck receiver and input stalls
		rx_hold_req = HOLD_CYCLES;
		repeat (6)
			send_text({8'h30, 8'h31, 8'h32}, 1'b1);
		drain_results();
	endtask

	task automatic test_sender_pause();
		in_gap_max    = 3;
		out_stall_max = 6;
		send_pattern({8'hC3, 8'h3C}, 1'b1);
		repeat (3) begin
			send_text({8'h3C, 8'hC3, 8'h3C, 8'hC3}, 1'b1);
			drain_results();
			send_word(ssfm_pkg::MODE_TEXT, 8'hC3, 1'b0);
			send_word(ssfm_pkg::MODE_END, 8'h3C, 1'b1);
		end
		drain_results();
	endtask

	task automatic test_random_search(input int word_budget);
		int         stop_at;
		int         r;
		int         plen;
		int         tlen;
		int         at;
		logic [7:0] alpha [3];
		logic [7:0] pat [$];
		logic [7:0] txt [$];
		stop_at = words_sent + word_budget;
		pat = {};
		while (words_sent < stop_at) begin
			in_gap_max    = ($urandom_range(0, 4) == 0) ? 0 : 6;
			out_stall_max = ($urandom_range(0, 4) == 0) ? 0 : 6;
			r = $urandom_range(0, 99);
			if (r < 8) begin
				// noise words
				repeat ($urandom_range(1, 3))
					send_word(ssfm_pkg::mode_t'(2'($urandom_range(0, 3))), 8'($urandom),
						1'($urandom));
				pat = {};
			end else if (r < 14) begin
				send_word(ssfm_pkg::MODE_EMPTY, 8'($urandom), 1'($urandom));
				pat = {};
			end else begin
				// new pattern over a small alphabet so matches are common
				if (pat.size() == 0 || $urandom_range(0, 2) == 0) begin
					for (int i = 0; i < 3; i++)
						alpha[i] = 8'($urandom);
					plen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) :
						$urandom_range(1, 4);
					pat = {};
					repeat (plen)
						pat.push_back(alpha[$urandom_range(0, 2)]);
					send_pattern(pat, $urandom_range(0, 7) != 0);
				end
				repeat ($urandom_range(1, 3)) begin
					tlen = $urandom_range(0, 16);
					txt = {};
					repeat (tlen)
						txt.push_back(alpha[$urandom_range(0, 2)]);
					if (tlen >= pat.size() && $urandom_range(0, 2) == 0) begin
						at = $urandom_range(0, tlen - pat.size());
						for (int i = 0; i < pat.size(); i++)
							txt[at + i] = pat[i];
					end
					r = $urandom_range(0, 9);
					if (r == 0) begin
						// left open: continued or abandoned later
						send_text(txt, 1'b0);
					end else if (tlen == 0 || r < 3) begin
						send_text(txt, 1'b0);
						send_word(ssfm_pkg::MODE_END, 8'($urandom), 1'($urandom));
					end else begin
						send_text(txt, 1'b1);
					end
				end
				if ($urandom_range(0, 9) == 0)
					drain_results();
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n          = 1'b0;
		in_ch.valid     = 1'b0;
		in_ch.mode      = ssfm_pkg::MODE_PATTERN;
		in_ch.data_byte = 8'h00;
		in_ch.last      = 1'b0;
		out_ch.ready    = 1'b0;
		words_sent      = 0;
		results_checked = 0;
		errors          = 0;
		idle_cycles     = 0;
		in_gap_max      = 0;
		out_stall_max   = 0;
		rx_stall_left   = 0;
		rx_hold_req     = 0;
		rx_hold_left    = 0;
		pat_len         = 0;
		pat_closed      = 1'b1;
		clear_search();

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		test_directed();
		test_overflow();
		test_backpressure();
		test_sender_pause();
		test_random_search(RANDOM_WORDS);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d input words and checked %0d result words across directed, overflow,",
			words_sent, results_checked);
		$display("backpressure, sender-pause and random search phases; %0d mismatches.", errors);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
